// ----- design/rht_pkg.sv -----
// Shared constants, entry layout and controller/datapath command types
// for the Robin Hood hash table. No dependencies.
`default_nettype none
package rht_pkg;

    localparam int CAPACITY   = 256;
    localparam int HASH_BITS  = 32;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = IDX_W + 1;
    localparam int PROBE_W    = CNT_W;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic [PROBE_W-1:0]    probe;
        logic [HASH_BITS-1:0]  hash;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_READ,
        CMD_READ_NEXT,
        CMD_STEP,
        CMD_FOUND,
        CMD_REPLACE,
        CMD_DEL_START,
        CMD_DEL_SHIFT,
        CMD_DEL_END,
        CMD_INS_START,
        CMD_INS_PLACE,
        CMD_INS_SWAP,
        CMD_INS_SKIP,
        CMD_RESP
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [2:0] status;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       rd_valid;
        logic       rd_match;
        logic       rd_lower;
        logic       rd_low_probe;
        logic       n_last;
        logic       full;
        logic       out_free;
    } dp_flags_t;

endpackage
`default_nettype wire

// ----- design/robin_hood_hash_table.sv -----
// Robin Hood hash table, CAPACITY slots, linear probing, backward-shift
// remove. One word in, one result word out. An operation reads and then
// checks each slot that it visits through the single-read slot memory, with
// an accept step before and a respond step after; an insert of a new key
// walks again from home up to the free slot, and a remove reads and shifts
// back each following entry and ends with a final check. A waiting result
// only stalls the next response. Occupancy bits clear at reset, so the table
// is ready at once; the result register lets the next word be accepted while
// a result waits. Uses rht_pkg, rht_ctrl, rht_datapath.
`default_nettype none
module robin_hood_hash_table (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_func,
    input  wire logic [rht_pkg::HASH_BITS-1:0]  s_key_hash,
    input  wire logic [rht_pkg::KEY_BITS-1:0]   s_entry_key,
    input  wire logic [rht_pkg::VALUE_BITS-1:0] s_entry_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [2:0]                          m_status,
    output logic [rht_pkg::VALUE_BITS-1:0]      m_result_value,
    output logic [rht_pkg::CNT_W-1:0]           m_entries_held
);
    import rht_pkg::*;

    ctl_cmd_t  ctl;
    dp_flags_t flags;

    rht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .flags   (flags),
        .ctl     (ctl)
    );

    rht_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_func         (s_func),
        .s_key_hash     (s_key_hash),
        .s_entry_key    (s_entry_key),
        .s_entry_value  (s_entry_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_value (m_result_value),
        .m_entries_held (m_entries_held),
        .ctl            (ctl),
        .flags          (flags)
    );

endmodule
`default_nettype wire

// ----- design/rht_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none
module rht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- design/rht_ctrl.sv -----
// Operation sequencer for the hash table: probe, replace, insert and
// backward-shift remove. Uses rht_pkg; drives rht_datapath by commands.
`default_nettype none
module rht_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rht_pkg::dp_flags_t flags,
    output rht_pkg::ctl_cmd_t      ctl
);
    import rht_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_F_RD, S_F_CHK, S_I_RD, S_I_CHK, S_D_RD, S_D_CHK, S_RESP
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] status_reg, status_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        ctl.cmd     = CMD_NONE;
        ctl.status  = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.cmd    = CMD_LOAD;
                    state_next = S_F_RD;
                end
            end
            S_F_RD: begin
                ctl.cmd    = CMD_READ;
                state_next = S_F_CHK;
            end
            S_F_CHK: begin
                if (flags.rd_valid && flags.rd_match) begin
                    state_next = S_RESP;
                    case (flags.func)
                        FUNC_INSERT: begin
                            ctl.cmd     = CMD_REPLACE;
                            status_next = ST_REPLACED;
                        end
                        FUNC_LOOKUP: begin
                            ctl.cmd     = CMD_FOUND;
                            status_next = ST_FOUND;
                        end
                        FUNC_REMOVE: begin
                            ctl.cmd     = CMD_DEL_START;
                            status_next = ST_REMOVED;
                            state_next  = S_D_RD;
                        end
                        default: status_next = ST_NOTFOUND;
                    endcase
                end else if (flags.rd_valid && !flags.n_last) begin
                    ctl.cmd    = CMD_STEP;
                    state_next = S_F_RD;
                end else if (flags.func == FUNC_INSERT) begin
                    if (flags.full) begin
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end else begin
                        ctl.cmd    = CMD_INS_START;
                        state_next = S_I_RD;
                    end
                end else begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_RESP;
                end
            end
            S_I_RD: begin
                ctl.cmd    = CMD_READ;
                state_next = S_I_CHK;
            end
            S_I_CHK: begin
                if (!flags.rd_valid) begin
                    ctl.cmd     = CMD_INS_PLACE;
                    status_next = ST_INSERTED;
                    state_next  = S_RESP;
                end else if (flags.rd_lower) begin
                    ctl.cmd    = CMD_INS_SWAP;
                    state_next = S_I_RD;
                end else begin
                    ctl.cmd    = CMD_INS_SKIP;
                    state_next = S_I_RD;
                end
            end
            S_D_RD: begin
                ctl.cmd    = CMD_READ_NEXT;
                state_next = S_D_CHK;
            end
            S_D_CHK: begin
                // stop at an empty slot, an entry at its home, or the shift bound
                if (!flags.rd_valid || flags.rd_low_probe || flags.n_last) begin
                    ctl.cmd    = CMD_DEL_END;
                    state_next = S_RESP;
                end else begin
                    ctl.cmd    = CMD_DEL_SHIFT;
                    state_next = S_D_RD;
                end
            end
            S_RESP: begin
                if (flags.out_free) begin
                    ctl.cmd    = CMD_RESP;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_NOTFOUND;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    a_resp_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.cmd == CMD_RESP) |-> flags.out_free)
        else $error("response issued while output word still pending");
    a_place_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.cmd == CMD_INS_START) |-> !flags.full)
        else $error("insert started on a full table");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_F_RD))
        else $error("accepted word did not start a probe");

endmodule
`default_nettype wire

// ----- design/rht_datapath.sv -----
// Slot store, occupancy bits, carried entry, probe pointers and output
// word register. Uses rht_pkg and rht_ram; steered by rht_ctrl.
`default_nettype none
module rht_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [1:0]                       s_func,
    input  wire logic [rht_pkg::HASH_BITS-1:0]    s_key_hash,
    input  wire logic [rht_pkg::KEY_BITS-1:0]     s_entry_key,
    input  wire logic [rht_pkg::VALUE_BITS-1:0]   s_entry_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [2:0]                            m_status,
    output logic [rht_pkg::VALUE_BITS-1:0]        m_result_value,
    output logic [rht_pkg::CNT_W-1:0]             m_entries_held,
    input  wire rht_pkg::ctl_cmd_t                ctl,
    output rht_pkg::dp_flags_t                    flags
);
    import rht_pkg::*;

    logic [1:0]            func_reg;
    logic [HASH_BITS-1:0]  hash_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      n_reg;
    logic [CNT_W-1:0]      count_reg;
    entry_t                carry_reg;
    logic [CAPACITY-1:0]   occ_reg;
    logic                  rd_valid_reg;
    logic                  m_valid_reg;
    logic [2:0]            m_status_reg;
    logic [VALUE_BITS-1:0] m_value_reg;
    logic [CNT_W-1:0]      m_held_reg;
    logic [VALUE_BITS-1:0] result_reg;

    entry_t           rd_entry;
    entry_t           wr_entry;
    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] idx_inc;

    assign idx_inc = idx_reg + IDX_W'(1);
    assign raddr   = (ctl.cmd == CMD_READ_NEXT) ? idx_inc : idx_reg;
    assign ram_re  = (ctl.cmd == CMD_READ) || (ctl.cmd == CMD_READ_NEXT);

    always_comb begin
        ram_we   = 1'b0;
        wr_entry = carry_reg;
        case (ctl.cmd)
            CMD_REPLACE: begin
                ram_we   = 1'b1;
                wr_entry = rd_entry;
                wr_entry.value = value_reg;
            end
            CMD_INS_PLACE, CMD_INS_SWAP: ram_we = 1'b1;
            CMD_DEL_SHIFT: begin
                ram_we   = 1'b1;
                wr_entry = rd_entry;
                wr_entry.probe = rd_entry.probe - PROBE_W'(1);
            end
            default: ram_we = 1'b0;
        endcase
    end

    rht_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(CAPACITY)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rd_entry)
    );

    always_comb begin
        flags.func         = func_reg;
        flags.rd_valid     = rd_valid_reg;
        flags.rd_match     = (rd_entry.hash == hash_reg) && (rd_entry.key == key_reg);
        flags.rd_lower     = rd_entry.probe < carry_reg.probe;
        flags.rd_low_probe = rd_entry.probe <= PROBE_W'(1);
        flags.n_last       = (n_reg == IDX_W'(CAPACITY - 1));
        flags.full         = (count_reg == CNT_W'(CAPACITY));
        flags.out_free     = !m_valid_reg || m_ready;
    end

    // payload and pointers
    always_ff @(posedge aclk) begin
        if (ram_re) begin
            rd_valid_reg <= occ_reg[raddr];
        end
        case (ctl.cmd)
            CMD_LOAD: begin
                func_reg   <= s_func;
                hash_reg   <= s_key_hash;
                key_reg    <= s_entry_key;
                value_reg  <= s_entry_value;
                idx_reg    <= s_key_hash[IDX_W-1:0];
                n_reg      <= '0;
                result_reg <= '0;
            end
            CMD_STEP: begin
                idx_reg <= idx_inc;
                n_reg   <= n_reg + IDX_W'(1);
            end
            CMD_FOUND, CMD_REPLACE: result_reg <= rd_entry.value;
            CMD_DEL_START: begin
                result_reg <= rd_entry.value;
                n_reg      <= '0;
            end
            CMD_DEL_SHIFT: begin
                idx_reg <= idx_inc;
                n_reg   <= n_reg + IDX_W'(1);
            end
            CMD_INS_START: begin
                carry_reg.probe <= PROBE_W'(1);
                carry_reg.hash  <= hash_reg;
                carry_reg.key   <= key_reg;
                carry_reg.value <= value_reg;
                idx_reg         <= hash_reg[IDX_W-1:0];
            end
            CMD_INS_SWAP: begin
                carry_reg.probe <= rd_entry.probe + PROBE_W'(1);
                carry_reg.hash  <= rd_entry.hash;
                carry_reg.key   <= rd_entry.key;
                carry_reg.value <= rd_entry.value;
                idx_reg         <= idx_inc;
            end
            CMD_INS_SKIP: begin
                carry_reg.probe <= carry_reg.probe + PROBE_W'(1);
                idx_reg         <= idx_inc;
            end
            CMD_RESP: begin
                // hold the output word while the next operation runs
                m_status_reg <= ctl.status;
                m_value_reg  <= result_reg;
                m_held_reg   <= count_reg;
            end
            default: ;
        endcase
    end

    // control state: occupancy, fill count, output word valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl.cmd == CMD_INS_PLACE) begin
                occ_reg[idx_reg] <= 1'b1;
                count_reg        <= count_reg + CNT_W'(1);
            end else if (ctl.cmd == CMD_DEL_END) begin
                occ_reg[idx_reg] <= 1'b0;
                count_reg        <= count_reg - CNT_W'(1);
            end
            if (ctl.cmd == CMD_RESP) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_value = m_value_reg;
    assign m_entries_held = m_held_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_reg) == int'(count_reg))
        else $error("entry count disagrees with occupancy");
    a_del_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.cmd == CMD_DEL_END) |-> (count_reg != '0) && occ_reg[idx_reg])
        else $error("remove emptied an unoccupied slot");

endmodule
`default_nettype wire
